// ===== hw/rtl/dvc_pkg.sv =====
// Shared types, constants and register codes for the dual-voice chorus.
`timescale 1ns / 1ps
package dvc_pkg;

   localparam int DELAY_DEPTH_DEF = 2048;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int SAMPLE_W   = 16;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_LEN_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_LEN_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_A    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH_B    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LFO_STEPS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_A     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_B     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MIX        = 3'd7;

   // 0.225 in Q.16, used by the sine refinement step.
   localparam logic [15:0] SIN_K = 16'd14746;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_SQ1,
      OP_SQ2,
      OP_CORR,
      OP_SCALE,
      OP_LEN,
      OP_STEP,
      OP_READ,
      OP_WET_A,
      OP_WET_B,
      OP_DRY,
      OP_WMIX,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   voice;
   } dvc_cmd_type;

   typedef struct packed {
      logic clear_done;
   } dvc_status_type;

endpackage

// ===== hw/rtl/dual_voice_chorus.sv =====
// Top level of the two-voice chorus: sequencer plus datapath.
//
// Each req_ transaction carries one signed Q1.15 sample; each rsp_ transaction
// returns one mixed Q1.15 sample, saturated. Both voices run a 24-bit phase
// accumulator feeding a parabolic sine, which modulates the length of that
// voice's circular delay line.
// A sample is taken when req_valid is high and req_stall low. The work runs on
// one shared 25x34 multiplier and one port per delay line: 19 steps after the
// load cycle. req_stall stays high through the steps, so a new sample is taken
// only once the final step has written the result.
// The result sits in an output register; a new sample is accepted while it
// waits. If rsp_stall holds the previous result, the final step waits for it.
// After reset both delay lines are cleared, one entry per cycle, through all
// DelayDepth entries; req_stall stays high meanwhile. Configuration writes
// through the csr_ port are taken at any time and belong between transactions.
`timescale 1ns / 1ps
module dual_voice_chorus #(
   parameter int DelayDepth = dvc_pkg::DELAY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [dvc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dvc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [dvc_pkg::SAMPLE_W-1:0] req_in_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dvc_pkg::SAMPLE_W-1:0] rsp_out_sample
);
   import dvc_pkg::*;

   dvc_cmd_type    cmd;
   dvc_status_type status;

   dvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dvc_dp #(
      .DelayDepth (DelayDepth)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_in_sample  (req_in_sample),
      .cmd            (cmd),
      .status         (status),
      .rsp_out_sample (rsp_out_sample)
   );

endmodule

// ===== hw/rtl/dvc_ctrl.sv =====
// Sequencer that steps the chorus datapath through one sample transaction.
`timescale 1ns / 1ps
module dvc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dvc_pkg::dvc_cmd_type   cmd,
   input  dvc_pkg::dvc_status_type status
);
   import dvc_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN} state_type;

   localparam logic [4:0] LAST_STEP = 5'd18;

   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_ok;

   // The final step writes the output register, so it waits for a free slot.
   assign out_ok = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.op    = OP_IDLE;
      cmd.voice = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.op = OP_CLEAR;
         ST_IDLE: begin
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_RUN: begin
            cmd.voice = (step_ff >= 5'd7) && (step_ff < 5'd14);
            unique case (step_ff)
               5'd0, 5'd7:   cmd.op = OP_SQ1;
               5'd1, 5'd8:   cmd.op = OP_SQ2;
               5'd2, 5'd9:   cmd.op = OP_CORR;
               5'd3, 5'd10:  cmd.op = OP_SCALE;
               5'd4, 5'd11:  cmd.op = OP_LEN;
               5'd5, 5'd12:  cmd.op = OP_STEP;
               5'd6, 5'd13:  cmd.op = OP_READ;
               5'd14:        cmd.op = OP_WET_A;
               5'd15:        cmd.op = OP_WET_B;
               5'd16:        cmd.op = OP_DRY;
               5'd17:        cmd.op = OP_WMIX;
               5'd18:        cmd.op = out_ok ? OP_OUT : OP_IDLE;
               default:      cmd.op = OP_IDLE;
            endcase
         end
         default: cmd.op = OP_IDLE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == LAST_STEP) begin
               if (out_ok) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/dvc_dp.sv =====
// Datapath of the chorus: registers, sine arithmetic, delay lines and output mixer.
`timescale 1ns / 1ps
module dvc_dp #(
   parameter int DelayDepth = dvc_pkg::DELAY_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [dvc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dvc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic signed [dvc_pkg::SAMPLE_W-1:0]   req_in_sample,
   input  dvc_pkg::dvc_cmd_type                  cmd,
   output dvc_pkg::dvc_status_type               status,
   output logic signed [dvc_pkg::SAMPLE_W-1:0]   rsp_out_sample
);
   import dvc_pkg::*;

   localparam int AW   = $clog2(DelayDepth);
   localparam int LENW = ((AW > 11) ? AW : 11) + 2;
   localparam logic signed [LENW-1:0] LEN_MAX = LENW'(DelayDepth - 1);
   localparam logic signed [LENW-1:0] LEN_ONE = LENW'(1);
   localparam logic [23:0] HALF = 24'h800000;

   // Configuration registers.
   logic [10:0]        base_a_ff, base_b_ff, depth_a_ff, depth_b_ff;
   logic [23:0]        step_a_ff, step_b_ff;
   logic signed [15:0] gain_a_ff, gain_b_ff;
   logic [15:0]        mix_ff;

   // Per-voice state.
   logic [23:0]   phase_a_ff, phase_b_ff;
   logic [AW-1:0] idx_a_ff, idx_b_ff;
   logic [AW-1:0] clr_ff;

   // Working registers.
   logic signed [15:0] x_ff;
   logic signed [58:0] prod_ff;
   logic [23:0]        a_ff;
   logic               neg_ff;
   logic [AW-1:0]      len_ff;
   logic signed [33:0] wet_ff;
   logic signed [48:0] acc_ff;
   logic signed [15:0] rd_a_ff, rd_b_ff;
   logic signed [15:0] out_ff;

   logic signed [15:0] line_a_mem [DelayDepth];
   logic signed [15:0] line_b_mem [DelayDepth];

   // Voice selection.
   logic [23:0]   phase_v, av, a_new, t_val, corr, r_val;
   logic [10:0]   base_v, depth_v, mag;
   logic [AW-1:0] idx_v, idx_nxt;
   logic [AW:0]   idx_inc;
   logic signed [LENW-1:0] base_cl, len_sum, len_cl;
   logic [16:0]   m_val, m_diff;

   logic signed [24:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [58:0] mul_p;
   logic               mul_en;

   logic signed [48:0] acc_sum;
   logic signed [19:0] y_val;
   logic signed [15:0] y_sat;

   logic          we_a, we_b;
   logic [AW-1:0] wa;
   logic signed [15:0] wd;

   assign phase_v = cmd.voice ? phase_b_ff : phase_a_ff;
   assign base_v  = cmd.voice ? base_b_ff  : base_a_ff;
   assign depth_v = cmd.voice ? depth_b_ff : depth_a_ff;
   assign idx_v   = cmd.voice ? idx_b_ff   : idx_a_ff;

   // Distance of the phase from the half-turn point.
   assign av    = phase_v[23] ? {1'b0, phase_v[22:0]} : (HALF - phase_v);
   assign a_new = prod_ff[44:21];
   assign t_val = prod_ff[46:23];
   assign corr  = prod_ff[39:16];
   assign r_val = a_ff - corr;
   assign mag   = prod_ff[33:23];

   assign m_val  = (mix_ff > 16'd32768) ? 17'd32768 : {1'b0, mix_ff};
   assign m_diff = 17'd32768 - m_val;

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_en = 1'b1;
      case (cmd.op)
         OP_SQ1: begin
            mul_a = {1'b0, av};
            mul_b = {10'b0, HALF - av};
         end
         OP_SQ2: begin
            mul_a = {1'b0, a_new};
            mul_b = {10'b0, HALF - a_new};
         end
         OP_CORR: begin
            mul_a = {1'b0, t_val};
            mul_b = {18'b0, SIN_K};
         end
         OP_SCALE: begin
            mul_a = {1'b0, r_val};
            mul_b = {23'b0, depth_v};
         end
         OP_WET_A: begin
            mul_a = 25'(gain_a_ff);
            mul_b = 34'(rd_a_ff);
         end
         OP_WET_B: begin
            mul_a = 25'(gain_b_ff);
            mul_b = 34'(rd_b_ff);
         end
         OP_DRY: begin
            mul_a = {8'b0, m_diff};
            mul_b = 34'(x_ff);
         end
         OP_WMIX: begin
            mul_a = {8'b0, m_val};
            mul_b = wet_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Delay length: clamped base plus or minus the modulation, clamped again.
   always_comb begin
      base_cl = LENW'(base_v);
      if (base_cl < LEN_ONE) base_cl = LEN_ONE;
      if (base_cl > LEN_MAX) base_cl = LEN_MAX;
      len_sum = neg_ff ? (base_cl - LENW'(mag)) : (base_cl + LENW'(mag));
      len_cl  = len_sum;
      if (len_cl < LEN_ONE) len_cl = LEN_ONE;
      if (len_cl > LEN_MAX) len_cl = LEN_MAX;
   end

   assign idx_inc = {1'b0, idx_v} + (AW+1)'(1);
   assign idx_nxt = (idx_inc >= {1'b0, len_ff}) ? '0 : idx_inc[AW-1:0];

   assign acc_sum = acc_ff + prod_ff[48:0];
   assign y_val   = acc_sum[48:29];
   always_comb begin
      if (y_val > 20'sd32767)       y_sat = 16'sh7fff;
      else if (y_val < -20'sd32768) y_sat = -16'sh8000;
      else                          y_sat = y_val[15:0];
   end

   // Memory write port: clearing pass or the sample of this transaction.
   assign we_a = (cmd.op == OP_CLEAR) || ((cmd.op == OP_STEP) && !cmd.voice);
   assign we_b = (cmd.op == OP_CLEAR) || ((cmd.op == OP_STEP) && cmd.voice);
   assign wa   = (cmd.op == OP_CLEAR) ? clr_ff : idx_v;
   assign wd   = (cmd.op == OP_CLEAR) ? 16'sd0 : x_ff;

   always_ff @(posedge clock) begin
      if (we_a) line_a_mem[wa] <= wd;
      if ((cmd.op == OP_READ) && !cmd.voice) rd_a_ff <= line_a_mem[idx_a_ff];
   end

   always_ff @(posedge clock) begin
      if (we_b) line_b_mem[wa] <= wd;
      if ((cmd.op == OP_READ) && cmd.voice) rd_b_ff <= line_b_mem[idx_b_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_a_ff  <= 11'd480;
         base_b_ff  <= 11'd480;
         depth_a_ff <= '0;
         depth_b_ff <= '0;
         step_a_ff  <= '0;
         step_b_ff  <= '0;
         gain_a_ff  <= 16'sd16384;
         gain_b_ff  <= 16'sd16384;
         mix_ff     <= '0;
         phase_a_ff <= '0;
         phase_b_ff <= '0;
         idx_a_ff   <= '0;
         idx_b_ff   <= '0;
         clr_ff     <= '0;
      end else begin
         if (cmd.op == OP_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (cmd.op == OP_STEP) begin
            if (cmd.voice) idx_b_ff <= idx_nxt;
            else           idx_a_ff <= idx_nxt;
         end
         if (cmd.op == OP_OUT) begin
            phase_a_ff <= phase_a_ff + step_a_ff;
            phase_b_ff <= phase_b_ff + step_b_ff;
         end
         if (csr_wen) begin
            unique case (csr_index)
               REG_BASE_LEN_A: base_a_ff  <= csr_wdata[10:0];
               REG_BASE_LEN_B: base_b_ff  <= csr_wdata[10:0];
               REG_DEPTH_A:    depth_a_ff <= csr_wdata[10:0];
               REG_DEPTH_B:    depth_b_ff <= csr_wdata[10:0];
               REG_LFO_STEPS: begin
                  step_a_ff  <= csr_wdata[23:0];
                  step_b_ff  <= csr_wdata[47:24];
                  phase_a_ff <= '0;
                  phase_b_ff <= '0;
               end
               REG_GAIN_A:     gain_a_ff  <= csr_wdata[15:0];
               REG_GAIN_B:     gain_b_ff  <= csr_wdata[15:0];
               REG_MIX:        mix_ff     <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) prod_ff <= mul_p;
      case (cmd.op)
         OP_LOAD:  x_ff <= req_in_sample;
         OP_SQ1:   neg_ff <= phase_v[23] && (phase_v[22:0] != 23'd0);
         OP_SQ2:   a_ff <= a_new;
         OP_LEN:   len_ff <= len_cl[AW-1:0];
         OP_WET_B: wet_ff <= prod_ff[33:0];
         OP_DRY:   wet_ff <= wet_ff + prod_ff[33:0];
         OP_WMIX:  acc_ff <= {prod_ff[34:0], 14'b0};
         OP_OUT:   out_ff <= y_sat;
         default: ;
      endcase
   end

   assign status.clear_done = (cmd.op == OP_CLEAR) && (clr_ff == AW'(DelayDepth - 1));
   assign rsp_out_sample    = out_ff;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the dual-voice chorus, with a scoreboard that predicts each output.
`timescale 1ns / 1ps
module testbench;
   import dvc_pkg::*;

   localparam int LINE_DEPTH  = DELAY_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 400;

   class chorus_scoreboard;
      logic signed [15:0] line_a[LINE_DEPTH];
      logic signed [15:0] line_b[LINE_DEPTH];
      int unsigned        idx_a, idx_b;
      logic [23:0]        phase_a, phase_b;
      logic [10:0]        base_a, base_b, depth_a, depth_b;
      logic [47:0]        lfo_steps;
      logic [15:0]        gain_a, gain_b, mix;
      logic signed [15:0] expected_samples[$];
      int                 errors;

      function new();
         for (int i = 0; i < LINE_DEPTH; i++) begin
            line_a[i] = '0;
            line_b[i] = '0;
         end
         idx_a = 0; idx_b = 0;
         phase_a = '0; phase_b = '0;
         base_a = 11'd480; base_b = 11'd480;
         depth_a = '0; depth_b = '0;
         lfo_steps = '0;
         gain_a = 16'd16384; gain_b = 16'd16384;
         mix = '0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_BASE_LEN_A: base_a = data[10:0];
            REG_BASE_LEN_B: base_b = data[10:0];
            REG_DEPTH_A:    depth_a = data[10:0];
            REG_DEPTH_B:    depth_b = data[10:0];
            REG_LFO_STEPS: begin
               lfo_steps = data;
               phase_a = '0;
               phase_b = '0;
            end
            REG_GAIN_A:     gain_a = data[15:0];
            REG_GAIN_B:     gain_b = data[15:0];
            REG_MIX:        mix = data[15:0];
            default: ;
         endcase
      endfunction

      // Parabolic sine with one refinement, scaled by depth and truncated toward zero.
      function longint sine_offset(logic [23:0] ph, logic [10:0] depth);
         longint v, av, a, t, r, m;
         bit     neg;
         v = longint'(ph) - 64'sd8388608;
         neg = v > 0;
         av = (v < 0) ? -v : v;
         a = (av * (64'sd8388608 - av)) >>> 21;
         t = (a * (64'sd8388608 - a)) >>> 23;
         r = a - ((t * longint'(SIN_K)) >>> 16);
         m = (longint'(depth) * r) >>> 23;
         return neg ? -m : m;
      endfunction

      function longint wrap_length(logic [10:0] base, logic [10:0] depth, logic [23:0] ph);
         longint b, len;
         b = longint'(base);
         if (b < 1) b = 1;
         if (b > LINE_DEPTH - 1) b = LINE_DEPTH - 1;
         len = b + sine_offset(ph, depth);
         if (len < 1) len = 1;
         if (len > LINE_DEPTH - 1) len = LINE_DEPTH - 1;
         return len;
      endfunction

      function void note_input(logic signed [15:0] x);
         longint len_a, len_b, rd_a, rd_b, m, wet, acc, y;
         len_a = wrap_length(base_a, depth_a, phase_a);
         len_b = wrap_length(base_b, depth_b, phase_b);
         line_a[idx_a] = x;
         idx_a++;
         if (idx_a >= len_a) idx_a = 0;
         rd_a = longint'(line_a[idx_a]);
         line_b[idx_b] = x;
         idx_b++;
         if (idx_b >= len_b) idx_b = 0;
         rd_b = longint'(line_b[idx_b]);
         phase_a = phase_a + lfo_steps[23:0];
         phase_b = phase_b + lfo_steps[47:24];
         m = (mix > 16'd32768) ? 32768 : longint'(mix);
         wet = longint'($signed(gain_a)) * rd_a + longint'($signed(gain_b)) * rd_b;
         acc = 64'sd16384 * (64'sd32768 - m) * longint'(x) + m * wet;
         y = acc >>> 29;
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         expected_samples.push_back(y[15:0]);
      endfunction

      function void check_result(logic signed [15:0] y);
         logic signed [15:0] want;
         if (expected_samples.size() == 0) begin
            $error("out_sample: unexpected transaction, actual %0d", y);
            errors++;
         end else begin
            want = expected_samples.pop_front();
            if (y !== want) begin
               $error("out_sample: expected %0d, actual %0d", want, y);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_wen;
   logic [CSR_IDX_W-1:0]         csr_index;
   logic [CSR_DATA_W-1:0]        csr_wdata;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [SAMPLE_W-1:0]   req_in_sample;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [SAMPLE_W-1:0]   rsp_out_sample;

   chorus_scoreboard sb = new();
   int  burst_left = 0;
   bit  hold_rx = 0;
   int  rx_mode = 0;
   int  cycles = 0;

   dual_voice_chorus u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_out_sample);
   end

   // Receiver: no stall, random or periodic stall patterns, plus a long hold-off on request.
   initial begin
      int phase_cnt;
      phase_cnt = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         phase_cnt++;
         if (hold_rx) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rx = 0;
            rsp_stall <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               default: rsp_stall <= ((phase_cnt % 7) < 3);
            endcase
         end
         if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic send_sample(logic signed [15:0] x);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_sample <= x;
      do @(posedge clock); while (req_stall);
      sb.note_input(x);
      burst_left--;
   endtask

   // Lower valid, then let every outstanding transaction drain before touching registers.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'($urandom_range(0, 255) - 128);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [10:0] random_len();
      case ($urandom_range(0, 7))
         0: return 11'd0;
         1: return 11'd1;
         2: return 11'd2047;
         3: return 11'($urandom_range(1, 40));
         default: return 11'($urandom());
      endcase
   endfunction

   task automatic random_config();
      logic [47:0] steps;
      logic [15:0] mx;
      write_csr(REG_BASE_LEN_A, 48'(random_len()));
      write_csr(REG_BASE_LEN_B, 48'(random_len()));
      write_csr(REG_DEPTH_A, 48'(random_len()));
      write_csr(REG_DEPTH_B, 48'(random_len()));
      case ($urandom_range(0, 3))
         0: steps = {16'($urandom()), $urandom()};
         1: steps = 48'hFFFF_FFFF_FFFF;
         default: steps = {24'($urandom_range(0, 300000)), 24'($urandom_range(0, 300000))};
      endcase
      if ($urandom_range(0, 3) != 0)
         steps = {4'd0, 20'($urandom_range(0, 400000)), 4'd0, 20'($urandom_range(0, 400000))};
      write_csr(REG_LFO_STEPS, steps);
      write_csr(REG_GAIN_A, 48'(($urandom_range(0, 4) == 0) ? 16'h8000 : 16'($urandom())));
      write_csr(REG_GAIN_B, 48'(($urandom_range(0, 4) == 0) ? 16'h7FFF : 16'($urandom())));
      case ($urandom_range(0, 5))
         0: mx = 16'd0;
         1: mx = 16'd32768;
         2: mx = 16'($urandom());
         default: mx = 16'($urandom_range(0, 32768));
      endcase
      write_csr(REG_MIX, 48'(mx));
   endtask

   initial begin
      int n;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_in_sample = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: dry only, so each output equals its input.
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(-16'sd1);
      send_sample(16'sd1);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      drain();

      // Wet only with the largest gains drives the sum past plus one and saturates.
      write_csr(REG_MIX, 48'd32768);
      write_csr(REG_GAIN_A, 48'h7FFF);
      write_csr(REG_GAIN_B, 48'h7FFF);
      write_csr(REG_BASE_LEN_A, 48'd1);
      write_csr(REG_BASE_LEN_B, 48'd2);
      for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh7FFF : 16'sh8000);
      drain();

      // Mix above full scale, zero and maximal base, full depth so lengths clamp at both ends.
      write_csr(REG_MIX, 48'hFFFF);
      write_csr(REG_GAIN_A, 48'h8000);
      write_csr(REG_GAIN_B, 48'h8000);
      write_csr(REG_BASE_LEN_A, 48'd0);
      write_csr(REG_BASE_LEN_B, 48'd2047);
      write_csr(REG_DEPTH_A, 48'd2047);
      write_csr(REG_DEPTH_B, 48'd2047);
      write_csr(REG_LFO_STEPS, {24'h080000, 24'h100000});
      for (int i = 0; i < 8; i++) send_sample(random_sample());
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         random_config();
         n = $urandom_range(50, 90);
         for (int i = 0; i < n; i++) begin
            if (ph == 2 && i == 5) hold_rx = 1;
            send_sample(random_sample());
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
